>>> rtl/core/pif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pif_pkg;

  // default sizes of the vertex table and of one coordinate
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 32;

  // configuration register file
  localparam int            VCOUNT_W         = 5;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd3;
  localparam logic          REG_VERTEX_COUNT = 1'b0;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // product terms of one triangle test, in issue order
  typedef enum logic [2:0] {
    STEP_DET_P = 3'd0,  // ax * by
    STEP_DET_N = 3'd1,  // bx * ay
    STEP_NA_P  = 3'd2,  // px * by
    STEP_NA_N  = 3'd3,  // bx * py
    STEP_NB_P  = 3'd4,  // ax * py
    STEP_NB_N  = 3'd5   // px * ay
  } step_t;

  typedef struct packed {
    logic  clear;
    logic  issue;
    step_t step;
  } tri_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/pif_tri_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module pif_tri_unit #(
  parameter int COORD_BITS = pif_pkg::COORD_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire pif_pkg::tri_ctrl_t       ctrl,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  output logic                          in_tri
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int ACC_W  = PROD_W + 2;

  logic signed [COORD_BITS-1:0] op_a;
  logic signed [COORD_BITS-1:0] op_b;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      prod_ext;
  pif_pkg::step_t               prod_step;
  logic                         prod_valid;
  logic signed [ACC_W-1:0]      det;
  logic signed [ACC_W-1:0]      na;
  logic signed [ACC_W-1:0]      nb;
  logic signed [ACC_W-1:0]      sum;

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctrl.step)
      pif_pkg::STEP_DET_P: begin op_a = ax; op_b = by; end
      pif_pkg::STEP_DET_N: begin op_a = bx; op_b = ay; end
      pif_pkg::STEP_NA_P:  begin op_a = px; op_b = by; end
      pif_pkg::STEP_NA_N:  begin op_a = bx; op_b = py; end
      pif_pkg::STEP_NB_P:  begin op_a = ax; op_b = py; end
      pif_pkg::STEP_NB_N:  begin op_a = px; op_b = ay; end
      default:             begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod      <= op_a * op_b;
      prod_step <= ctrl.step;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // accumulate the product issued in the previous cycle
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      det <= '0;
      na  <= '0;
      nb  <= '0;
    end else if (prod_valid) begin
      unique case (prod_step)
        pif_pkg::STEP_DET_P: det <= det + prod_ext;
        pif_pkg::STEP_DET_N: det <= det - prod_ext;
        pif_pkg::STEP_NA_P:  na  <= na + prod_ext;
        pif_pkg::STEP_NA_N:  na  <= na - prod_ext;
        pif_pkg::STEP_NB_P:  nb  <= nb + prod_ext;
        pif_pkg::STEP_NB_N:  nb  <= nb - prod_ext;
        default:             det <= det;
      endcase
    end
  end

  assign sum = na + nb;

  // weights both non-negative and summing to at most one, sign-aware; false when det is zero
  always_comb begin
    if (det > 0) begin
      in_tri = (na >= 0) && (nb >= 0) && (sum <= det);
    end else if (det < 0) begin
      in_tri = (na <= 0) && (nb <= 0) && (sum >= det);
    end else begin
      in_tri = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/point_in_fan_polygon_test.sv
// timing: a write loads the output register at transfer time if free, else from S_DONE;
//   a query runs read, six products, drain and evaluate per edge until a hit or last edge
// throughput: one item at a time; a query holds the input side for its whole edge walk,
//   set by the single shared 32x32 multiplier that forms six products per triangle
// reset: synchronous, clears the sequencer and out_valid and sets vertex_count to 3;
//   the vertex table is not cleared and reads of unwritten entries are undefined
`timescale 1ns / 1ps
`default_nettype none

module point_in_fan_polygon_test #(
  parameter int MAX_VERTICES = pif_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pif_pkg::COORD_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            op,
  input  wire [3:0]                      vertex_index,
  input  wire logic signed [COORD_BITS-1:0] coord_x,
  input  wire logic signed [COORD_BITS-1:0] coord_y,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           inside_res,
  output logic [3:0]                     hit_edge,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [2:0]                      paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [pif_pkg::VCOUNT_W-1:0] vertex_count;
  logic                         cfg_write;

  // vertex table, one row per vertex
  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  // query context
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic [CNT_W-1:0]             n_cnt;
  logic [CNT_W-1:0]             n_eff;
  logic [IDX_W-1:0]             edge_idx;
  logic [IDX_W-1:0]             addr_a;
  logic [IDX_W-1:0]             addr_b;
  logic                         last_edge;
  pif_pkg::step_t               step;
  pif_pkg::step_t               step_next;

  // pending result
  logic                         res_inside;
  logic [3:0]                   res_edge;

  logic                         in_xfer;
  logic                         is_write;
  logic                         wr_in_range;
  logic                         quick_result;
  logic                         out_free;
  logic                         out_load;
  logic                         out_load_inside;
  logic [3:0]                   out_load_edge;

  pif_pkg::tri_ctrl_t           ctrl;
  logic                         tri_inside;

  // ---------------------------------------------------------------------------------------
  // configuration port: always ready, one register, selected by paddr[2] == 0
  // ---------------------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == pif_pkg::REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pif_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= pwdata[pif_pkg::VCOUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == pif_pkg::REG_VERTEX_COUNT) begin
      prdata = {{(32 - pif_pkg::VCOUNT_W){1'b0}}, vertex_count};
    end else begin
      prdata = '0;
    end
  end

  // count above the table size saturates to the table size
  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(vertex_count);
    end
  end

  // ---------------------------------------------------------------------------------------
  // input transfer
  // ---------------------------------------------------------------------------------------
  assign in_stall    = (state != S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign is_write    = (op == pif_pkg::OP_WRITE);
  assign wr_in_range = (32'(vertex_index) < 32'(MAX_VERTICES));
  // writes and queries against an empty table answer without an edge walk
  assign quick_result = is_write || (n_eff == '0);

  // output register frees up when empty or taken in this cycle
  assign out_free = !out_valid || !out_stall;

  // vertex writes land at transfer time; indices outside the table are dropped
  always_ff @(posedge clk) begin
    if (in_xfer && is_write && wr_in_range) begin
      mem_x[IDX_W'(vertex_index)] <= coord_x;
      mem_y[IDX_W'(vertex_index)] <= coord_y;
    end
  end

  // ---------------------------------------------------------------------------------------
  // edge walk: closing edge (last, vertex 0) first, then (i, i-1) for rising i
  // ---------------------------------------------------------------------------------------
  always_comb begin
    if (edge_idx == '0) begin
      addr_a = IDX_W'(n_cnt - 1'b1);
      addr_b = '0;
    end else begin
      addr_a = edge_idx;
      addr_b = edge_idx - 1'b1;
    end
  end

  assign last_edge = (CNT_W'(edge_idx) == CNT_W'(n_cnt - 1'b1));

  // registered read of both edge vertices
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      ax <= mem_x[addr_a];
      ay <= mem_y[addr_a];
      bx <= mem_x[addr_b];
      by <= mem_y[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !is_write) begin
      px    <= coord_x;
      py    <= coord_y;
      n_cnt <= n_eff;
    end
  end

  // next product term of the sequence
  always_comb begin
    unique case (step)
      pif_pkg::STEP_DET_P: step_next = pif_pkg::STEP_DET_N;
      pif_pkg::STEP_DET_N: step_next = pif_pkg::STEP_NA_P;
      pif_pkg::STEP_NA_P:  step_next = pif_pkg::STEP_NA_N;
      pif_pkg::STEP_NA_N:  step_next = pif_pkg::STEP_NB_P;
      pif_pkg::STEP_NB_P:  step_next = pif_pkg::STEP_NB_N;
      default:             step_next = pif_pkg::STEP_DET_P;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (quick_result) begin
            state_next = out_free ? S_IDLE : S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ:  state_next = S_MUL;
      S_MUL: begin
        if (step == pif_pkg::STEP_NB_N) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_EVAL;
      S_EVAL: begin
        if (tri_inside || last_edge) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pif_pkg::STEP_DET_P;
    end else if (state == S_MUL) begin
      step <= step_next;
    end else begin
      step <= pif_pkg::STEP_DET_P;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      edge_idx <= '0;
    end else if ((state == S_EVAL) && !tri_inside && !last_edge) begin
      edge_idx <= edge_idx + 1'b1;
    end
  end

  // result held while waiting for the output register
  always_ff @(posedge clk) begin
    if (in_xfer && quick_result) begin
      res_inside <= 1'b0;
      res_edge   <= '0;
    end else if (state == S_EVAL) begin
      res_inside <= tri_inside;
      res_edge   <= tri_inside ? 4'(edge_idx) : 4'd0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // shared triangle unit
  // ---------------------------------------------------------------------------------------
  assign ctrl = '{clear: (state == S_READ), issue: (state == S_MUL), step: step};

  pif_tri_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_tri (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .px     (px),
    .py     (py),
    .ax     (ax),
    .ay     (ay),
    .bx     (bx),
    .by     (by),
    .in_tri (tri_inside)
  );

  // ---------------------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------------------
  always_comb begin
    if ((state == S_IDLE) && in_xfer && quick_result && out_free) begin
      out_load        = 1'b1;
      out_load_inside = 1'b0;
      out_load_edge   = '0;
    end else if ((state == S_DONE) && out_free) begin
      out_load        = 1'b1;
      out_load_inside = res_inside;
      out_load_edge   = res_edge;
    end else begin
      out_load        = 1'b0;
      out_load_inside = res_inside;
      out_load_edge   = res_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inside_res <= out_load_inside;
      hit_edge   <= out_load_edge;
    end
  end

endmodule

`default_nettype wire
